// File: rtl/psc_pkg.sv
package psc_pkg;

	localparam int unsigned MAX_LIMIT_DEF = 65535;
	localparam int unsigned LIMIT_W = 16;
	localparam int unsigned COUNT_W = 13;
	localparam int unsigned STEP_W = 4;

	localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
	localparam logic [STEP_W-1:0] S_INIT  = 4'd1;
	localparam logic [STEP_W-1:0] S_PSET  = 4'd2;
	localparam logic [STEP_W-1:0] S_PCHK  = 4'd3;
	localparam logic [STEP_W-1:0] S_PWAIT = 4'd4;
	localparam logic [STEP_W-1:0] S_MARK  = 4'd5;
	localparam logic [STEP_W-1:0] S_PNEXT = 4'd6;
	localparam logic [STEP_W-1:0] S_CCLR  = 4'd7;
	localparam logic [STEP_W-1:0] S_CNT   = 4'd8;
	localparam logic [STEP_W-1:0] S_CTAIL = 4'd9;
	localparam logic [STEP_W-1:0] S_OUT   = 4'd10;

	typedef enum logic [2:0] {
		C_NONE,
		C_ALWAYS,
		C_START,
		C_ILIM,
		C_SQGT,
		C_RDZ,
		C_MEND
	} cond_t;

	typedef enum logic [2:0] {
		I_HOLD,
		I_CLR,
		I_INC,
		I_LDSQ,
		I_ADDP
	} iop_t;

	typedef enum logic [1:0] {
		P_HOLD,
		P_INIT,
		P_INC
	} pop_t;

	typedef struct packed {
		cond_t             cond;
		logic              hold;
		logic [STEP_W-1:0] jump;
		iop_t              iop;
		pop_t              pop;
		logic              mem_wr;
		logic              wr_init;
		logic              mem_rd;
		logic              rd_p;
		logic              acc;
		logic              cnt_clr;
		logic              done;
	} ctrl_t;

	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t c;
		c = '{cond: C_NONE, hold: 1'b0, jump: S_IDLE, iop: I_HOLD, pop: P_HOLD,
			mem_wr: 1'b0, wr_init: 1'b0, mem_rd: 1'b0, rd_p: 1'b0, acc: 1'b0,
			cnt_clr: 1'b0, done: 1'b0};
		case (step)
			S_IDLE: begin
				c.cond = C_START; c.hold = 1'b1; c.jump = S_INIT; c.iop = I_CLR;
			end
			S_INIT: begin
				c.cond = C_ILIM; c.hold = 1'b1; c.jump = S_PSET; c.iop = I_INC;
				c.mem_wr = 1'b1; c.wr_init = 1'b1;
			end
			S_PSET: begin
				c.cond = C_ALWAYS; c.jump = S_PCHK; c.pop = P_INIT;
			end
			S_PCHK: begin
				c.cond = C_SQGT; c.jump = S_CCLR; c.mem_rd = 1'b1; c.rd_p = 1'b1;
			end
			S_PWAIT: begin
				c.cond = C_RDZ; c.jump = S_PNEXT; c.iop = I_LDSQ;
			end
			S_MARK: begin
				c.cond = C_MEND; c.hold = 1'b1; c.jump = S_PNEXT; c.iop = I_ADDP;
				c.mem_wr = 1'b1;
			end
			S_PNEXT: begin
				c.cond = C_ALWAYS; c.jump = S_PCHK; c.pop = P_INC;
			end
			S_CCLR: begin
				c.iop = I_CLR; c.cnt_clr = 1'b1;
			end
			S_CNT: begin
				c.cond = C_ILIM; c.hold = 1'b1; c.jump = S_CTAIL; c.iop = I_INC;
				c.mem_rd = 1'b1; c.acc = 1'b1;
			end
			S_CTAIL: begin
				c.cond = C_NONE;
			end
			S_OUT: begin
				c.cond = C_ALWAYS; c.jump = S_IDLE; c.done = 1'b1;
			end
			default: begin
				c.cond = C_ALWAYS; c.jump = S_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

// File: rtl/prime_sieve_counter_unit.sv
// Channel   Signals                      Direction  Transfer
// request   start, busy, upper_limit     in         start high while busy low
// result    done, prime_count            out        done high for one cycle
//
// A request initialises the flag memory up to L, strikes the multiples of each prime p
// with p*p <= L from p*p upward, then counts the flags still set; the flag memory
// is read or written at most once per cycle.
// Reset clears the control state; the flag memory is rewritten by each request.
// Busy stays high from the transfer until the cycle after done; results cannot be stalled.
module prime_sieve_counter_unit #(
	parameter int unsigned MAX_LIMIT = psc_pkg::MAX_LIMIT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [psc_pkg::LIMIT_W-1:0]  upper_limit,
	output logic                         done,
	output logic [psc_pkg::COUNT_W-1:0]  prime_count
);

	localparam int unsigned AW = $clog2(MAX_LIMIT + 1);

	logic [psc_pkg::STEP_W-1:0]  step_q;
	logic [psc_pkg::STEP_W-1:0]  step_nxt;
	psc_pkg::ctrl_t              ctrl;
	logic                        cond_true;

	logic [AW-1:0]               lim_q;
	logic [AW:0]                 i_q;
	logic [AW-1:0]               p_q;
	logic [AW:0]                 sq_q;
	logic [psc_pkg::COUNT_W-1:0] count_q;
	logic                        acc_q;
	logic                        rd_q;
	logic [AW:0]                 i_plus_p;
	logic [AW-1:0]               rd_addr;

	logic                        flags [0:MAX_LIMIT];

	assign ctrl     = psc_pkg::ucode(step_q);
	assign i_plus_p = i_q + {1'b0, p_q};
	assign rd_addr  = ctrl.rd_p ? p_q : i_q[AW-1:0];

	always_comb begin
		case (ctrl.cond)
			psc_pkg::C_NONE:   cond_true = 1'b0;
			psc_pkg::C_ALWAYS: cond_true = 1'b1;
			psc_pkg::C_START:  cond_true = start;
			psc_pkg::C_ILIM:   cond_true = (i_q == {1'b0, lim_q});
			psc_pkg::C_SQGT:   cond_true = (sq_q > {1'b0, lim_q});
			psc_pkg::C_RDZ:    cond_true = !rd_q;
			psc_pkg::C_MEND:   cond_true = (i_plus_p > {1'b0, lim_q});
			default:           cond_true = 1'b1;
		endcase
		if (cond_true) begin
			step_nxt = ctrl.jump;
		end else if (ctrl.hold) begin
			step_nxt = step_q;
		end else begin
			step_nxt = step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= psc_pkg::S_IDLE;
			acc_q   <= 1'b0;
			count_q <= '0;
		end else begin
			step_q <= step_nxt;
			acc_q  <= ctrl.acc;
			if (ctrl.cnt_clr) begin
				count_q <= '0;
			end else if (acc_q && rd_q) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_q == psc_pkg::S_IDLE && start) begin
			if (32'(upper_limit) > MAX_LIMIT) begin
				lim_q <= AW'(MAX_LIMIT);
			end else begin
				lim_q <= AW'(upper_limit);
			end
		end
		case (ctrl.iop)
			psc_pkg::I_CLR:  i_q <= '0;
			psc_pkg::I_INC:  i_q <= i_q + 1'b1;
			psc_pkg::I_LDSQ: i_q <= sq_q;
			psc_pkg::I_ADDP: i_q <= i_plus_p;
			default:         i_q <= i_q;
		endcase
		case (ctrl.pop)
			psc_pkg::P_INIT: begin
				p_q  <= AW'(2);
				sq_q <= (AW + 1)'(4);
			end
			psc_pkg::P_INC: begin
				p_q  <= p_q + 1'b1;
				sq_q <= sq_q + {p_q, 1'b1};
			end
			default: begin
				p_q  <= p_q;
				sq_q <= sq_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.mem_wr) begin
			flags[i_q[AW-1:0]] <= ctrl.wr_init && (i_q >= (AW + 1)'(2));
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mem_rd) begin
			rd_q <= flags[rd_addr];
		end
	end

	assign busy        = (step_q != psc_pkg::S_IDLE);
	assign done        = ctrl.done;
	assign prime_count = count_q;

endmodule

// File: verif/tb_prime_sieve_counter_unit.sv
`timescale 1ns / 1ps

module tb_prime_sieve_counter_unit;

	localparam int unsigned CYCLE_LIMIT = 10000000;
	localparam int unsigned SETTLE_CYCLES = 32;
	localparam int unsigned RANDOM_ITEMS = 84;
	localparam int unsigned QUIET_ITEMS = 30;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [psc_pkg::LIMIT_W-1:0] upper_limit;
	logic                        done;
	logic [psc_pkg::COUNT_W-1:0] prime_count;

	logic [psc_pkg::COUNT_W-1:0] expected_counts[$];
	int unsigned                 mismatch_count;
	int unsigned                 cycle_count;
	bit                          gaps_enabled;

	prime_sieve_counter_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.upper_limit(upper_limit),
		.done       (done),
		.prime_count(prime_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [psc_pkg::COUNT_W-1:0] count_primes(
		input logic [psc_pkg::LIMIT_W-1:0] lim
	);
		bit          is_candidate [0:psc_pkg::MAX_LIMIT_DEF];
		int unsigned span;
		int unsigned p;
		int unsigned k;
		int unsigned total;
		span = (lim > psc_pkg::MAX_LIMIT_DEF) ? psc_pkg::MAX_LIMIT_DEF : lim;
		total = 0;
		for (k = 0; k <= span; k++) begin
			is_candidate[k] = 1'b1;
		end
		is_candidate[0] = 1'b0;
		if (span >= 1) begin
			is_candidate[1] = 1'b0;
		end
		for (p = 2; p * p <= span; p++) begin
			if (is_candidate[p]) begin
				for (k = p * p; k <= span; k += p) begin
					is_candidate[k] = 1'b0;
				end
			end
		end
		for (k = 0; k <= span; k++) begin
			if (is_candidate[k]) begin
				total++;
			end
		end
		return total[psc_pkg::COUNT_W-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// One request transfer: optional idle gap, then hold start until the block takes it.
	task automatic send_limit(input logic [psc_pkg::LIMIT_W-1:0] lim);
		@(negedge clk);
		if (gaps_enabled && $urandom_range(99) < 38) begin
			start <= 1'b0;
			do begin
				upper_limit <= psc_pkg::LIMIT_W'($urandom);
				@(negedge clk);
			end while ($urandom_range(99) < 38);
		end
		start <= 1'b1;
		upper_limit <= lim;
		forever begin
			@(posedge clk);
			if (!busy) begin
				break;
			end
		end
		expected_counts.push_back(count_primes(lim));
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (expected_counts.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [psc_pkg::LIMIT_W-1:0] rand_limit();
		if ($urandom_range(99) < 85) begin
			return psc_pkg::LIMIT_W'($urandom_range(1023));
		end
		return psc_pkg::LIMIT_W'($urandom_range(4095));
	endfunction

	task automatic test_small_limits();
		int unsigned lim;
		for (lim = 0; lim <= 5; lim++) begin
			send_limit(psc_pkg::LIMIT_W'(lim));
		end
		send_limit(psc_pkg::LIMIT_W'(97));
		send_limit(psc_pkg::LIMIT_W'(120));
	endtask

	task automatic test_square_bounds();
		send_limit(psc_pkg::LIMIT_W'(9));
		send_limit(psc_pkg::LIMIT_W'(24));
		send_limit(psc_pkg::LIMIT_W'(25));
		send_limit(psc_pkg::LIMIT_W'(48));
		send_limit(psc_pkg::LIMIT_W'(49));
		send_limit(psc_pkg::LIMIT_W'(121));
		send_limit(psc_pkg::LIMIT_W'(1023));
		send_limit(psc_pkg::LIMIT_W'(1024));
		send_limit(psc_pkg::LIMIT_W'(4095));
	endtask

	task automatic test_full_range();
		send_limit(psc_pkg::LIMIT_W'(psc_pkg::MAX_LIMIT_DEF));
		send_limit(psc_pkg::LIMIT_W'(2));
	endtask

	task automatic test_random_limits();
		int unsigned n;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			gaps_enabled = (n >= QUIET_ITEMS);
			send_limit(rand_limit());
			if (n == RANDOM_ITEMS / 2) begin
				drain_results();
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_counts.size() == 0) begin
				report_mismatch($sformatf("unexpected result, prime_count=%0d", prime_count));
			end else begin
				if (prime_count !== expected_counts[0]) begin
					report_mismatch($sformatf("prime_count=%0d, expected %0d",
						prime_count, expected_counts[0]));
				end
				void'(expected_counts.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		upper_limit = '0;
		mismatch_count = 0;
		cycle_count = 0;
		gaps_enabled = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_small_limits();
		test_square_bounds();
		drain_results();
		test_full_range();
		test_random_limits();
		drain_results();

		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/psc_pkg.sv
rtl/prime_sieve_counter_unit.sv
verif/tb_prime_sieve_counter_unit.sv
